[hw/rtl/hgpp_pkg.sv]
// Shared types, widths and constants of the hex grid point picker.
package hgpp_pkg;

    localparam int POINT_W    = 16;
    localparam int DIM_W      = 8;
    localparam int COUNT_W    = 7;
    localparam int TILE_IDX_W = 12;
    localparam int CFG_IDX_W  = 2;

    localparam int MAP_W   = 18;
    localparam int COORD_W = 19;
    localparam int IDX_W   = 2 * COUNT_W;
    localparam int CNT_W   = COUNT_W + 2;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int D2_W    = SQ_W + 1;
    localparam int D25_W   = D2_W + 5;
    localparam int H2_W    = 2 * DIM_W;
    localparam int LIMIT_W = H2_W + 7;

    localparam int RADIUS_NUM = 121;

    localparam int QUEUE_DEPTH = 2;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT   = 2'd3;

    localparam logic [DIM_W-1:0]   RST_TILE_WIDTH  = 8'd64;
    localparam logic [DIM_W-1:0]   RST_TILE_HEIGHT = 8'd64;
    localparam logic [COUNT_W-1:0] RST_ROW_COUNT   = 7'd1;
    localparam logic [COUNT_W-1:0] RST_COL_COUNT   = 7'd1;

    typedef struct packed {
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
        logic [COUNT_W-1:0] rows;
        logic [COUNT_W-1:0] cols;
    } t_cfg;

    typedef struct packed {
        logic [POINT_W-1:0] x;
        logic [POINT_W-1:0] y;
        logic               skip;
        logic [COUNT_W-1:0] start;
    } t_job;

    function automatic logic [DIM_W+1:0] triple(input logic [DIM_W-1:0] v);
        return {2'b00, v} + {1'b0, v, 1'b0};
    endfunction

endpackage

[hw/rtl/hgpp_point_if.sv]
// Query point channel.
interface hgpp_point_if;
    logic                         valid;
    logic                         ready;
    logic [hgpp_pkg::POINT_W-1:0] point_x;
    logic [hgpp_pkg::POINT_W-1:0] point_y;

    modport source (output valid, output point_x, output point_y, input ready);
    modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

[hw/rtl/hgpp_result_if.sv]
// Picked tile result channel.
interface hgpp_result_if;
    logic                            valid;
    logic                            ready;
    logic                            hit;
    logic [hgpp_pkg::TILE_IDX_W-1:0] tile_index;

    modport source (output valid, output hit, output tile_index, input ready);
    modport sink   (input valid, input hit, input tile_index, output ready);
endinterface

[hw/rtl/hgpp_front.sv]
// Front end: accepts points, checks map bounds and finds the start row.
module hgpp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hgpp_pkg::t_cfg  i_cfg,
    hgpp_point_if.sink      i_point,
    output logic            o_push_valid,
    input  logic            i_push_ready,
    output hgpp_pkg::t_job  o_job
);
    import hgpp_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE,
        F_BOUND,
        F_CHECK,
        F_SCAN,
        F_PUSH
    } t_fstate;

    t_fstate            r_state;
    logic [POINT_W-1:0] r_x;
    logic [POINT_W-1:0] r_y;
    logic [MAP_W-1:0]   r_map_w4;
    logic [MAP_W-1:0]   r_map_h4;
    logic [MAP_W-1:0]   r_acc;
    logic [COUNT_W-1:0] r_i;
    logic               r_skip;
    logic [COUNT_W-1:0] r_start;

    logic [MAP_W-1:0] h3;
    logic [MAP_W-1:0] pitch;
    logic [MAP_W-1:0] px4;
    logic [MAP_W-1:0] py4;
    logic [MAP_W-1:0] wc;
    logic [MAP_W-1:0] hr;
    logic [COUNT_W-1:0] last_row;

    assign h3       = MAP_W'(triple(i_cfg.h));
    assign pitch    = h3 >> 2;
    assign px4      = {r_x, 2'b00};
    assign py4      = {r_y, 2'b00};
    assign last_row = i_cfg.rows - 7'd1;
    assign wc       = MAP_W'(i_cfg.w) * MAP_W'(i_cfg.cols);
    assign hr       = h3 * MAP_W'(last_row);

    assign i_point.ready = (r_state == F_IDLE);
    assign o_push_valid  = (r_state == F_PUSH);
    assign o_job         = '{x: r_x, y: r_y, skip: r_skip, start: r_start};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_point.valid) begin
                        r_x     <= i_point.point_x;
                        r_y     <= i_point.point_y;
                        r_state <= F_BOUND;
                    end
                end
                F_BOUND: begin
                    r_map_w4 <= (wc << 2) + ((i_cfg.rows > 7'd1) ? (MAP_W'(i_cfg.w) << 1)
                                                                : MAP_W'(0));
                    r_map_h4 <= (MAP_W'(i_cfg.h) << 2) + hr;
                    r_state  <= F_CHECK;
                end
                F_CHECK: begin
                    if (i_cfg.rows == '0 || i_cfg.cols == '0 ||
                        px4 > r_map_w4 || py4 > r_map_h4) begin
                        r_skip  <= 1'b1;
                        r_start <= '0;
                        r_state <= F_PUSH;
                    end else if (r_y < POINT_W'(i_cfg.h)) begin
                        r_skip  <= 1'b0;
                        r_start <= '0;
                        r_state <= F_PUSH;
                    end else if (py4 > r_map_h4 - h3) begin
                        r_skip  <= 1'b0;
                        r_start <= last_row;
                        r_state <= F_PUSH;
                    end else begin
                        r_skip  <= 1'b0;
                        r_acc   <= MAP_W'(i_cfg.h);
                        r_i     <= '0;
                        r_state <= F_SCAN;
                    end
                end
                F_SCAN: begin
                    if (MAP_W'(r_y) < r_acc) begin
                        r_start <= r_i;
                        r_state <= F_PUSH;
                    end else if (r_i == last_row) begin
                        r_start <= '0;
                        r_state <= F_PUSH;
                    end else begin
                        r_acc <= r_acc + pitch;
                        r_i   <= r_i + 7'd1;
                    end
                end
                F_PUSH: begin
                    if (i_push_ready) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

[hw/rtl/hgpp_queue.sv]
// Short job queue between the front and back ends.
module hgpp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  hgpp_pkg::t_job  i_job,
    output logic            o_pop_valid,
    input  logic            i_pop,
    output hgpp_pkg::t_job  o_job
);
    import hgpp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    t_job              r_entry [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_QW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_push_ready = (r_count != CNT_QW'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_job        = r_entry[r_rd_ptr];
    assign do_push      = i_push_valid && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_QW'(1);
                2'b01:   r_count <= r_count - CNT_QW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[hw/rtl/hgpp_back.sv]
// Back end: walks candidate tiles, keeps the nearest hit and holds the result.
module hgpp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hgpp_pkg::t_cfg  i_cfg,
    input  logic            i_job_valid,
    output logic            o_pop,
    input  hgpp_pkg::t_job  i_job,
    hgpp_result_if.source   o_result
);
    import hgpp_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE,
        B_INIT,
        B_RUN,
        B_DRAIN,
        B_DONE
    } t_bstate;

    t_bstate            r_state;
    t_job               r_job;
    logic [COORD_W-1:0] r_cx;
    logic [COORD_W-1:0] r_cy;
    logic [IDX_W-1:0]   r_idx;
    logic [COUNT_W-1:0] r_c;
    logic [COUNT_W-1:0] r_r;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_found;
    logic [D2_W-1:0]    r_best;
    logic [IDX_W-1:0]   r_best_idx;
    logic               r_out_valid;
    logic               r_out_hit;
    logic [TILE_IDX_W-1:0] r_out_idx;

    logic [H2_W-1:0]    r_h2;
    logic [LIMIT_W-1:0] r_limit;

    logic               r1_v, r2_v, r3_v, r4_v;
    logic               r1_last, r2_last, r3_last, r4_last;
    logic [IDX_W-1:0]   r1_idx, r2_idx, r3_idx, r4_idx;
    logic [COORD_W-1:0] r1_dx, r1_dy;
    logic [SQ_W-1:0]    r2_dx2, r2_dy2;
    logic [D2_W-1:0]    r3_d2, r4_d2;
    logic [D25_W-1:0]   r4_d25;

    logic [COORD_W-1:0] px, py;
    logic [DIM_W+1:0]   h3;
    logic [COORD_W-1:0] step_x, step_y;
    logic [COUNT_W+DIM_W+2:0] cy_mul;
    logic [IDX_W-1:0]   idx_mul;
    logic               gen_last;
    logic               row_end;
    logic               next_odd;

    assign px       = {1'b0, r_job.x, 2'b00};
    assign py       = {1'b0, r_job.y, 2'b00};
    assign h3       = triple(i_cfg.h);
    assign step_x   = COORD_W'({i_cfg.w, 2'b00});
    assign step_y   = COORD_W'(h3);
    assign cy_mul   = (COUNT_W+DIM_W+3)'(h3) * (COUNT_W+DIM_W+3)'(r_job.start);
    assign idx_mul  = IDX_W'(r_job.start) * IDX_W'(i_cfg.cols);
    assign row_end  = (r_c == i_cfg.cols - 7'd1);
    assign gen_last = (r_cnt == CNT_W'(1)) || (row_end && r_r == i_cfg.rows - 7'd1);
    assign next_odd = ~r_r[0];

    assign o_pop               = (r_state == B_IDLE) && i_job_valid;
    assign o_result.valid      = r_out_valid;
    assign o_result.hit        = r_out_hit;
    assign o_result.tile_index = r_out_idx;

    always_ff @(posedge i_clk) begin
        r_h2    <= H2_W'(i_cfg.h) * H2_W'(i_cfg.h);
        r_limit <= LIMIT_W'(r_h2) * LIMIT_W'(RADIUS_NUM);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            r1_v <= (r_state == B_RUN);
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
        r1_last <= gen_last;
        r1_idx  <= r_idx;
        r1_dx   <= (px > r_cx) ? px - r_cx : r_cx - px;
        r1_dy   <= (py > r_cy) ? py - r_cy : r_cy - py;
        r2_last <= r1_last;
        r2_idx  <= r1_idx;
        r2_dx2  <= SQ_W'(r1_dx) * SQ_W'(r1_dx);
        r2_dy2  <= SQ_W'(r1_dy) * SQ_W'(r1_dy);
        r3_last <= r2_last;
        r3_idx  <= r2_idx;
        r3_d2   <= D2_W'(r2_dx2) + D2_W'(r2_dy2);
        r4_last <= r3_last;
        r4_idx  <= r3_idx;
        r4_d2   <= r3_d2;
        r4_d25  <= D25_W'(r3_d2) + (D25_W'(r3_d2) << 3) + (D25_W'(r3_d2) << 4);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            if (r_out_valid && o_result.ready && r_state != B_DONE) begin
                r_out_valid <= 1'b0;
            end
            if (r4_v && r4_d25 < D25_W'(r_limit) && (!r_found || r4_d2 < r_best)) begin
                r_found    <= 1'b1;
                r_best     <= r4_d2;
                r_best_idx <= r4_idx;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (i_job_valid) begin
                        r_job   <= i_job;
                        r_found <= 1'b0;
                        r_state <= i_job.skip ? B_DONE : B_INIT;
                    end
                end
                B_INIT: begin
                    r_cx    <= r_job.start[0] ? COORD_W'({i_cfg.w, 2'b00})
                                              : COORD_W'({i_cfg.w, 1'b0});
                    r_cy    <= COORD_W'(cy_mul) + COORD_W'({i_cfg.h, 1'b0});
                    r_idx   <= idx_mul;
                    r_c     <= '0;
                    r_r     <= r_job.start;
                    r_cnt   <= CNT_W'({i_cfg.cols, 1'b0}) + CNT_W'(1);
                    r_state <= B_RUN;
                end
                B_RUN: begin
                    r_idx <= r_idx + IDX_W'(1);
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (row_end) begin
                        r_c  <= '0;
                        r_r  <= r_r + 7'd1;
                        r_cx <= next_odd ? COORD_W'({i_cfg.w, 2'b00})
                                         : COORD_W'({i_cfg.w, 1'b0});
                        r_cy <= r_cy + step_y;
                    end else begin
                        r_c  <= r_c + 7'd1;
                        r_cx <= r_cx + step_x;
                    end
                    if (gen_last) begin
                        r_state <= B_DRAIN;
                    end
                end
                B_DRAIN: begin
                    if (r4_v && r4_last) begin
                        r_state <= B_DONE;
                    end
                end
                B_DONE: begin
                    if (!r_out_valid || o_result.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_hit   <= r_found;
                        r_out_idx   <= r_found ? r_best_idx[TILE_IDX_W-1:0] : '0;
                        r_state     <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

[hw/rtl/hex_grid_point_picker.sv]
// Top level of the hex grid point picker: configuration registers and the front/back ends.
// Maps a pixel point to the index of the nearest hexagonal tile centre within 0.55 tile heights,
// on a grid whose odd rows are shifted by half a tile and whose rows are 3/4 tile height apart.
// Configuration registers are written through i_cfg_we/i_cfg_idx/i_cfg_data, and the user
// must write them only while no query is in flight; the block does not enforce this. The front
// end takes a point, checks it against the map bounds in its BOUND and CHECK states and, where
// that does not settle the start row, scans the row pitch one row per cycle (up to row_count
// rows) to find it. A two-entry queue hands the job to the back end, which tests one candidate
// tile per cycle, 2*col_count+1 candidates at most, through a four-stage distance pipeline,
// then loads the output register once the previous result is taken. A point off the map skips
// the candidate walk; the front end works on the next point meanwhile.
module hex_grid_point_picker #(
    parameter int MAX_ROWS = hgpp_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = hgpp_pkg::DEF_MAX_COLS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [hgpp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [hgpp_pkg::DIM_W-1:0]       i_cfg_data,
    hgpp_point_if.sink                       i_point,
    hgpp_result_if.source                    o_result
);
    import hgpp_pkg::*;

    logic [DIM_W-1:0]   r_tile_width;
    logic [DIM_W-1:0]   r_tile_height;
    logic [COUNT_W-1:0] r_row_count;
    logic [COUNT_W-1:0] r_col_count;

    t_cfg cfg;
    t_job front_job;
    t_job queue_job;
    logic push_valid;
    logic push_ready;
    logic job_valid;
    logic job_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_width  <= RST_TILE_WIDTH;
            r_tile_height <= RST_TILE_HEIGHT;
            r_row_count   <= RST_ROW_COUNT;
            r_col_count   <= RST_COL_COUNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TILE_WIDTH:  r_tile_width  <= i_cfg_data;
                CFG_TILE_HEIGHT: r_tile_height <= i_cfg_data;
                CFG_ROW_COUNT:   r_row_count   <= i_cfg_data[COUNT_W-1:0];
                CFG_COL_COUNT:   r_col_count   <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.w    = r_tile_width;
    assign cfg.h    = r_tile_height;
    assign cfg.rows = (32'(r_row_count) > MAX_ROWS) ? COUNT_W'(MAX_ROWS) : r_row_count;
    assign cfg.cols = (32'(r_col_count) > MAX_COLS) ? COUNT_W'(MAX_COLS) : r_col_count;

    hgpp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_point      (i_point),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_job        (front_job)
    );

    hgpp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_job        (front_job),
        .o_pop_valid  (job_valid),
        .i_pop        (job_pop),
        .o_job        (queue_job)
    );

    hgpp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job_valid (job_valid),
        .o_pop       (job_pop),
        .i_job       (queue_job),
        .o_result    (o_result)
    );

endmodule
